// File: src/srctok_pkg.sv
// Shared types, constants and character helpers for the source tokenizer.
package srctok_pkg;

  localparam int POS_W          = 17;
  localparam int VAL_W          = 63;
  localparam int KIND_W         = 5;
  localparam int MAX_RESULTS    = 3;
  localparam int NRES_W         = 2;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = 2;
  localparam int FIFO_CW        = 3;
  localparam int NUM_KW         = 3;
  localparam int KW_OFF_W       = 3;

  localparam logic [POS_W-1:0] MAX_SOURCE_BYTES = 17'd65536;
  localparam logic [VAL_W-1:0] VAL_MAX          = {VAL_W{1'b1}};

  localparam int KW_FN     = 0;
  localparam int KW_LET    = 1;
  localparam int KW_RETURN = 2;
  localparam int KW_MAX_LEN = 6;

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INT    = 5'd0,
    KIND_IDENT  = 5'd1,
    KIND_FN     = 5'd2,
    KIND_LET    = 5'd3,
    KIND_RETURN = 5'd4,
    KIND_LPAREN = 5'd5,
    KIND_RPAREN = 5'd6,
    KIND_LBRACE = 5'd7,
    KIND_RBRACE = 5'd8,
    KIND_SEMI   = 5'd9,
    KIND_EQUAL  = 5'd10,
    KIND_PLUS   = 5'd11,
    KIND_MINUS  = 5'd12,
    KIND_STAR   = 5'd13,
    KIND_SLASH  = 5'd14,
    KIND_END    = 5'd15,
    KIND_ERROR  = 5'd16
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_NUM     = 2'd1,
    MODE_IDENT   = 2'd2,
    MODE_DISCARD = 2'd3
  } scan_mode_t;

  typedef struct packed {
    token_kind_t token_kind;
    val_t        int_value;
    logic        value_overflow;
    pos_t        start_pos;
    pos_t        token_length;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [NRES_W-1:0]            count;
    result_t [MAX_RESULTS-1:0]    item;
  } bundle_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
           ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
  endfunction

  function automatic logic is_ident_start(input logic [7:0] b);
    return is_alpha(b) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_ident(input logic [7:0] b);
    return is_ident_start(b) || is_digit(b);
  endfunction

  function automatic token_kind_t punct_kind(input logic [7:0] b);
    token_kind_t k;
    case (b)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_SEMI:   k = KIND_SEMI;
      CH_EQUAL:  k = KIND_EQUAL;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic pos_t kw_len(input int k);
    pos_t len;
    case (k)
      KW_FN:   len = 17'd2;
      KW_LET:  len = 17'd3;
      default: len = 17'd6;
    endcase
    return len;
  endfunction

  // Keyword text packed left-aligned; offsets past the text read as zero.
  function automatic logic [7:0] kw_char(input int k, input logic [KW_OFF_W-1:0] off);
    logic [8*KW_MAX_LEN-1:0] txt;
    logic [8*KW_MAX_LEN-1:0] sh;
    case (k)
      KW_FN:   txt = {8'h66, 8'h6E, 32'h0};
      KW_LET:  txt = {8'h6C, 8'h65, 8'h74, 24'h0};
      default: txt = {8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E};
    endcase
    sh = txt << {off, 3'b000};
    return sh[8*KW_MAX_LEN-1 -: 8];
  endfunction

endpackage

// File: src/srctok_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
interface srctok_in_if;
  import srctok_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       final_byte;

  modport source (output valid, output source_byte, output final_byte, input ready);
  modport sink   (input valid, input source_byte, input final_byte, output ready);
endinterface

interface srctok_out_if;
  import srctok_pkg::*;
  logic        valid;
  logic        ready;
  token_kind_t token_kind;
  val_t        int_value;
  logic        value_overflow;
  pos_t        start_pos;
  pos_t        token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output int_value, output value_overflow,
                  output start_pos, output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input int_value, input value_overflow,
                  input start_pos, input token_length, input last_of_run, output ready);
endinterface

// File: src/srctok_scan.sv
// Scanner state and per-byte token logic: one byte in, up to three tokens out.
module srctok_scan
  import srctok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] src_byte,
  input  logic       fin,
  output bundle_t    bundle
);

  scan_mode_t        mode_r, mode_nxt, mode_mid;
  pos_t              pos_r, pos_nxt, pos_inc;
  pos_t              start_r, start_nxt, start_mid;
  val_t              acc_r, acc_nxt, acc_mid, acc_in, acc_upd;
  logic              ovf_r, ovf_nxt, ovf_mid, ovf_upd, ovf_hit;
  logic [NUM_KW-1:0] cand_r, cand_nxt, cand_mid, cand_in, cand_upd;

  logic        cont_num, cont_ident, handle_new, close_old;
  logic        new_num, new_ident, emit_single;
  token_kind_t single_kind;
  logic [VAL_W+3:0] acc_sum;
  pos_t        kw_off;

  function automatic result_t close_result(input scan_mode_t m, input val_t acc,
                                           input logic ovf, input logic [NUM_KW-1:0] cand,
                                           input pos_t start, input pos_t end_pos);
    result_t     r;
    token_kind_t k;
    pos_t        len;
    len = end_pos - start;
    k   = KIND_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (cand[i] && len == kw_len(i)) begin
        k = token_kind_t'(KIND_W'(KIND_FN) + KIND_W'(i));
      end
    end
    r                = '0;
    r.start_pos      = start;
    r.token_length   = len;
    if (m == MODE_NUM) begin
      r.token_kind     = KIND_INT;
      r.int_value      = acc;
      r.value_overflow = ovf;
    end else begin
      r.token_kind     = k;
    end
    return r;
  endfunction

  // byte classification against the current mode
  assign cont_num    = (mode_r == MODE_NUM) && is_digit(src_byte);
  assign cont_ident  = (mode_r == MODE_IDENT) && is_ident(src_byte);
  assign handle_new  = !cont_num && !cont_ident && (mode_r != MODE_DISCARD);
  assign close_old   = handle_new && (mode_r != MODE_IDLE);
  assign new_num     = handle_new && is_digit(src_byte);
  assign new_ident   = handle_new && is_ident_start(src_byte);
  assign emit_single = handle_new && !is_space(src_byte) && !is_digit(src_byte) &&
                       !is_ident_start(src_byte);
  assign single_kind = punct_kind(src_byte);
  assign pos_inc     = (pos_r < MAX_SOURCE_BYTES) ? pos_r + 17'd1 : MAX_SOURCE_BYTES;

  // decimal accumulate: acc*10 + digit, saturating
  assign acc_in  = new_num ? '0 : acc_r;
  assign acc_sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} +
                   {{(VAL_W-4){1'b0}}, (src_byte - CH_ZERO)};
  assign ovf_hit = |acc_sum[VAL_W+3:VAL_W];
  assign acc_upd = ovf_hit ? VAL_MAX : acc_sum[VAL_W-1:0];
  assign ovf_upd = (new_num ? 1'b0 : ovf_r) | ovf_hit;

  // keyword candidate tracking
  assign kw_off  = new_ident ? '0 : pos_r - start_r;
  assign cand_in = new_ident ? {NUM_KW{1'b1}} : cand_r;
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      cand_upd[k] = cand_in[k] && (kw_off < POS_W'(KW_MAX_LEN)) &&
                    (kw_char(k, kw_off[KW_OFF_W-1:0]) == src_byte);
    end
  end

  // state after this byte, before the final-byte handling
  always_comb begin
    mode_mid = MODE_IDLE;
    if (cont_num || new_num) begin
      mode_mid = MODE_NUM;
    end else if (cont_ident || new_ident) begin
      mode_mid = MODE_IDENT;
    end else if (mode_r == MODE_DISCARD) begin
      mode_mid = MODE_DISCARD;
    end else if (emit_single && single_kind == KIND_ERROR) begin
      mode_mid = MODE_DISCARD;
    end
    start_mid = (new_num || new_ident) ? pos_r : start_r;
    acc_mid   = (cont_num || new_num) ? acc_upd : acc_r;
    ovf_mid   = (cont_num || new_num) ? ovf_upd : ovf_r;
    cand_mid  = (cont_ident || new_ident) ? cand_upd : cand_r;
  end

  // next state
  always_comb begin
    if (fin) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      cand_nxt  = {NUM_KW{1'b1}};
    end else begin
      mode_nxt  = mode_mid;
      pos_nxt   = pos_inc;
      start_nxt = start_mid;
      acc_nxt   = acc_mid;
      ovf_nxt   = ovf_mid;
      cand_nxt  = cand_mid;
    end
  end

  // results for this byte
  always_comb begin
    logic [NRES_W-1:0] n;
    result_t           r;
    n           = '0;
    r           = '0;
    bundle.item = '0;
    if (close_old) begin
      bundle.item[n] = close_result(mode_r, acc_r, ovf_r, cand_r, start_r, pos_r);
      n = n + 2'd1;
    end
    if (emit_single) begin
      r              = '0;
      r.token_kind   = single_kind;
      r.start_pos    = pos_r;
      r.token_length = 17'd1;
      bundle.item[n] = r;
      n = n + 2'd1;
    end
    if (fin) begin
      if (mode_mid == MODE_NUM || mode_mid == MODE_IDENT) begin
        bundle.item[n] = close_result(mode_mid, acc_mid, ovf_mid, cand_mid, start_mid,
                                      pos_inc);
        n = n + 2'd1;
      end
      r              = '0;
      r.token_kind   = KIND_END;
      r.start_pos    = pos_inc;
      bundle.item[n] = r;
      n = n + 2'd1;
    end
    if (n != '0) begin
      bundle.item[n - 2'd1].last_of_run = 1'b1;
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      cand_r  <= {NUM_KW{1'b1}};
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      cand_r  <= cand_nxt;
    end
  end

endmodule

// File: src/srctok_fifo.sv
// Token queue: takes up to three tokens per push, pops one per ready cycle.
module srctok_fifo
  import srctok_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t bundle,
  input  logic    pop_ready,
  output logic    head_valid,
  output result_t head,
  output logic    has_room
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [NRES_W-1:0]    push_n;
  logic                 pop;

  assign push_n     = push ? bundle.count : '0;
  assign pop        = (count_r != '0) && pop_ready;
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign has_room   = count_r <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS);

  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign count_nxt  = count_r + FIFO_CW'(push_n) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push && (NRES_W'(i) < bundle.count)) begin
        mem[wr_ptr_r + FIFO_AW'(i)] <= bundle.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/source_tokenizer_core.sv
// Top level of the streaming source tokenizer.
// Takes one source byte per transfer and emits tokens (kind, integer value with saturation
// flag, start offset, length); last_of_run marks the final token caused by a byte. A byte
// is accepted every cycle as long as the four-entry token queue holds at most one token,
// so one byte per cycle is sustained while each byte yields at most one token and the
// output is ready; the tokens of a byte leave the output one at a time. Tokens of a byte
// are registered in the token queue at its transfer. The final byte closes any open token
// and adds an End token; the next byte then starts a new source at offset 0.
module source_tokenizer_core
  import srctok_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  srctok_in_if.sink      in_chan,
  srctok_out_if.source   out_chan
);

  logic    accept;
  logic    has_room;
  logic    head_valid;
  bundle_t bundle;
  result_t head;

  assign in_chan.ready = has_room;
  assign accept        = in_chan.valid && has_room;

  srctok_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .src_byte (in_chan.source_byte),
    .fin      (in_chan.final_byte),
    .bundle   (bundle)
  );

  srctok_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .bundle     (bundle),
    .pop_ready  (out_chan.ready),
    .head_valid (head_valid),
    .head       (head),
    .has_room   (has_room)
  );

  assign out_chan.valid          = head_valid;
  assign out_chan.token_kind     = head.token_kind;
  assign out_chan.int_value      = head.int_value;
  assign out_chan.value_overflow = head.value_overflow;
  assign out_chan.start_pos      = head.start_pos;
  assign out_chan.token_length   = head.token_length;
  assign out_chan.last_of_run    = head.last_of_run;

endmodule
